@@ hdl/asp_pkg.sv @@
// Shared types and codes for the archive stream parser.
// No dependencies; imported by every module of the block.
package asp_pkg;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_PLEN   = 3'd1,
      PH_PATH   = 3'd2,
      PH_SIZE   = 3'd3,
      PH_BODY   = 3'd4,
      PH_DONE   = 3'd5
   } asp_phase_type;

   localparam logic [2:0] EV_ABSORB = 3'd0;
   localparam logic [2:0] EV_PATH   = 3'd1;
   localparam logic [2:0] EV_BEGIN  = 3'd2;
   localparam logic [2:0] EV_BODY   = 3'd3;
   localparam logic [2:0] EV_END    = 3'd4;
   localparam logic [2:0] EV_ACCEPT = 3'd5;
   localparam logic [2:0] EV_ERROR  = 3'd6;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_MAGIC    = 3'd1;
   localparam logic [2:0] ERR_VERSION  = 3'd2;
   localparam logic [2:0] ERR_TOTALS   = 3'd3;
   localparam logic [2:0] ERR_PATHLEN  = 3'd4;
   localparam logic [2:0] ERR_OVERSIZE = 3'd5;
   localparam logic [2:0] ERR_EXTRA    = 3'd6;
   localparam logic [2:0] ERR_INCOMPL  = 3'd7;

   localparam logic [2:0] REG_MAGIC     = 3'd0;
   localparam logic [2:0] REG_VERSION   = 3'd1;
   localparam logic [2:0] REG_MAX_FILES = 3'd2;
   localparam logic [2:0] REG_MAX_TOTAL = 3'd3;
   localparam logic [2:0] REG_MAX_FILE  = 3'd4;
   localparam logic [2:0] REG_MAX_PATH  = 3'd5;

   localparam logic [4:0] HEADER_BYTES = 5'd18;
   localparam logic [4:0] MAGIC_END    = 5'd4;
   localparam logic [4:0] VERSION_END  = 5'd6;
   localparam logic [4:0] COUNT_END    = 5'd10;
   localparam logic [4:0] PLEN_BYTES   = 5'd2;
   localparam logic [4:0] SIZE_BYTES   = 5'd8;

   typedef struct packed {
      logic       is_finish;
      logic [7:0] data;
   } asp_item_type;

   typedef struct packed {
      logic [31:0] magic;
      logic [15:0] version;
      logic [31:0] max_files;
      logic [47:0] max_total;
      logic [47:0] max_file;
      logic [15:0] max_path;
   } asp_cfg_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  out_byte;
      logic [31:0] file_index;
      logic [47:0] file_size;
      logic [2:0]  error_code;
      logic        last;
   } asp_result_type;

endpackage

@@ hdl/asp_front.sv @@
// Front end: request queue of two entries, classifies each request.
// Depends on asp_pkg.
module asp_front import asp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_cmd,
   input  logic [7:0]   req_data_byte,
   output logic         head_valid,
   output asp_item_type head_item,
   input  logic         head_pop
);
   asp_item_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff].is_finish <= req_cmd;
         mem_ff[wr_ptr_ff].data      <= req_data_byte;
      end
   end
endmodule

@@ hdl/asp_back.sv @@
// Back end: archive parser state, limit checks and result output register.
// Depends on asp_pkg; fed by asp_front.
module asp_back import asp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  asp_cfg_type    cfg,
   input  logic           head_valid,
   input  asp_item_type   head_item,
   output logic           head_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output asp_result_type rsp_data
);
   asp_phase_type  phase_ff, phase_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic [63:0]    shift_ff, shift_in;
   logic [31:0]    magic_ff, magic_in;
   logic [15:0]    version_ff, version_in;
   logic [31:0]    files_decl_ff, files_decl_in;
   logic [63:0]    bytes_decl_ff, bytes_decl_in;
   logic [15:0]    path_len_ff, path_len_in;
   logic [15:0]    path_cnt_ff, path_cnt_in;
   logic [63:0]    size_ff, size_in;
   logic [63:0]    progress_ff, progress_in;
   logic [63:0]    sum_ff, sum_in;
   logic [63:0]    body_seen_ff, body_seen_in;
   logic [31:0]    files_seen_ff, files_seen_in;
   logic [2:0]     error_ff, error_in;

   asp_result_type out_ff, out_in, pend_ff, pend_in, r0, r1;
   logic           out_valid_ff, out_valid_in, pend_valid_ff, pend_valid_in;
   logic           two, fire, slot_free;

   logic [63:0]    shift_n, progress_n;
   logic [4:0]     cnt_n;
   logic [15:0]    plen_n, pcnt_n;
   logic [64:0]    sum_wide;
   logic [63:0]    sum_n;
   logic [31:0]    files_n;
   asp_phase_type  after_file;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign fire      = head_valid && !pend_valid_ff && slot_free;
   assign head_pop  = fire;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      shift_n    = {shift_ff[55:0], head_item.data};
      cnt_n      = cnt_ff + 5'd1;
      plen_n     = {shift_ff[7:0], head_item.data};
      pcnt_n     = path_cnt_ff + 16'd1;
      sum_wide   = {1'b0, sum_ff} + {1'b0, shift_n};
      sum_n      = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
      progress_n = progress_ff + 64'd1;
      files_n    = files_seen_ff + 32'd1;
      after_file = (files_n == files_decl_ff) ? PH_DONE : PH_PLEN;

      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      shift_in      = shift_ff;
      magic_in      = magic_ff;
      version_in    = version_ff;
      files_decl_in = files_decl_ff;
      bytes_decl_in = bytes_decl_ff;
      path_len_in   = path_len_ff;
      path_cnt_in   = path_cnt_ff;
      size_in       = size_ff;
      progress_in   = progress_ff;
      sum_in        = sum_ff;
      body_seen_in  = body_seen_ff;
      files_seen_in = files_seen_ff;
      error_in      = error_ff;

      r0 = '{event_res: EV_ABSORB, out_byte: 8'd0, file_index: files_seen_ff,
             file_size: 48'd0, error_code: ERR_NONE, last: 1'b1};
      r1 = '{event_res: EV_END, out_byte: 8'd0, file_index: files_seen_ff,
             file_size: 48'd0, error_code: ERR_NONE, last: 1'b1};
      two = 1'b0;

      if (error_ff != ERR_NONE) begin
         r0.event_res  = EV_ERROR;
         r0.error_code = error_ff;
      end else if (head_item.is_finish) begin
         if (phase_ff != PH_DONE || body_seen_ff != bytes_decl_ff) begin
            error_in      = ERR_INCOMPL;
            r0.event_res  = EV_ERROR;
            r0.error_code = ERR_INCOMPL;
         end else begin
            r0.event_res = EV_ACCEPT;
         end
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               shift_in = shift_n;
               cnt_in   = cnt_n;
               if (cnt_n == MAGIC_END) begin
                  magic_in = shift_n[31:0];
               end else if (cnt_n == VERSION_END) begin
                  version_in = shift_n[15:0];
               end else if (cnt_n == COUNT_END) begin
                  files_decl_in = shift_n[31:0];
               end else if (cnt_n == HEADER_BYTES) begin
                  bytes_decl_in = shift_n;
                  cnt_in        = 5'd0;
                  shift_in      = 64'd0;
                  if (magic_ff != cfg.magic) begin
                     error_in = ERR_MAGIC;
                  end else if (version_ff != cfg.version) begin
                     error_in = ERR_VERSION;
                  end else if (files_decl_ff == 32'd0 || files_decl_ff > cfg.max_files ||
                               shift_n > {16'd0, cfg.max_total}) begin
                     error_in = ERR_TOTALS;
                  end else begin
                     phase_in = PH_PLEN;
                  end
               end
            end
            PH_PLEN: begin
               shift_in = {48'd0, plen_n};
               cnt_in   = cnt_n;
               if (cnt_n == PLEN_BYTES) begin
                  path_len_in = plen_n;
                  cnt_in      = 5'd0;
                  shift_in    = 64'd0;
                  if (plen_n == 16'd0 || plen_n > cfg.max_path) begin
                     error_in = ERR_PATHLEN;
                  end else begin
                     path_cnt_in = 16'd0;
                     phase_in    = PH_PATH;
                  end
               end
            end
            PH_PATH: begin
               path_cnt_in = pcnt_n;
               if (pcnt_n == path_len_ff) begin
                  phase_in = PH_SIZE;
                  cnt_in   = 5'd0;
                  shift_in = 64'd0;
               end
               r0.event_res = EV_PATH;
               r0.out_byte  = head_item.data;
            end
            PH_SIZE: begin
               shift_in = shift_n;
               cnt_in   = cnt_n;
               if (cnt_n == SIZE_BYTES) begin
                  size_in     = shift_n;
                  cnt_in      = 5'd0;
                  shift_in    = 64'd0;
                  progress_in = 64'd0;
                  sum_in      = sum_n;
                  if (shift_n > {16'd0, cfg.max_file} || sum_n > bytes_decl_ff) begin
                     error_in = ERR_OVERSIZE;
                  end else if (shift_n == 64'd0) begin
                     r0.event_res  = EV_BEGIN;
                     r0.last       = 1'b0;
                     two           = 1'b1;
                     files_seen_in = files_n;
                     phase_in      = after_file;
                  end else begin
                     phase_in     = PH_BODY;
                     r0.event_res = EV_BEGIN;
                     r0.file_size = shift_n[47:0];
                  end
               end
            end
            PH_BODY: begin
               progress_in  = progress_n;
               body_seen_in = body_seen_ff + 64'd1;
               r0.event_res = EV_BODY;
               r0.out_byte  = head_item.data;
               r0.file_size = size_ff[47:0];
               if (progress_n >= size_ff) begin
                  r0.last       = 1'b0;
                  r1.file_size  = size_ff[47:0];
                  two           = 1'b1;
                  files_seen_in = files_n;
                  cnt_in        = 5'd0;
                  shift_in      = 64'd0;
                  phase_in      = after_file;
               end
            end
            default: begin
               error_in = ERR_EXTRA;
            end
         endcase
         if (error_in != ERR_NONE) begin
            r0 = '{event_res: EV_ERROR, out_byte: 8'd0, file_index: files_seen_ff,
                   file_size: 48'd0, error_code: error_in, last: 1'b1};
            two = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (slot_free) begin
         out_valid_in = pend_valid_ff || fire;
         out_in       = pend_valid_ff ? pend_ff : r0;
         if (pend_valid_ff) begin
            pend_valid_in = 1'b0;
         end
      end
      if (fire && two) begin
         pend_valid_in = 1'b1;
         pend_in       = r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         phase_ff      <= PH_HEADER;
         cnt_ff        <= 5'd0;
         shift_ff      <= 64'd0;
         magic_ff      <= 32'd0;
         version_ff    <= 16'd0;
         files_decl_ff <= 32'd0;
         bytes_decl_ff <= 64'd0;
         path_len_ff   <= 16'd0;
         path_cnt_ff   <= 16'd0;
         size_ff       <= 64'd0;
         progress_ff   <= 64'd0;
         sum_ff        <= 64'd0;
         body_seen_ff  <= 64'd0;
         files_seen_ff <= 32'd0;
         error_ff      <= ERR_NONE;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (fire) begin
            phase_ff      <= phase_in;
            cnt_ff        <= cnt_in;
            shift_ff      <= shift_in;
            magic_ff      <= magic_in;
            version_ff    <= version_in;
            files_decl_ff <= files_decl_in;
            bytes_decl_ff <= bytes_decl_in;
            path_len_ff   <= path_len_in;
            path_cnt_ff   <= path_cnt_in;
            size_ff       <= size_in;
            progress_ff   <= progress_in;
            sum_ff        <= sum_in;
            body_seen_ff  <= body_seen_in;
            files_seen_ff <= files_seen_in;
            error_ff      <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end
endmodule

@@ hdl/archive_stream_parser.sv @@
// Archive stream parser: takes one archive byte or a finish request per cycle
// while the request queue has room. A last body byte or an empty file yields two
// results and holds the parser until the second result enters the output register.
// Results come from the output register behind the two-entry request queue; the
// queue lets input continue while the result side stalls. Depends on asp_pkg,
// asp_front and asp_back.
module archive_stream_parser import asp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_out_byte,
   output logic [31:0] rsp_file_index,
   output logic [47:0] rsp_file_size,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   asp_cfg_type    cfg_ff;
   asp_item_type   head_item;
   asp_result_type rsp_data;
   logic           head_valid, head_pop, cfg_wr;
   logic [2:0]     reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[5:3];
   assign cfg_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic     <= 32'd0;
         cfg_ff.version   <= 16'd1;
         cfg_ff.max_files <= 32'd4096;
         cfg_ff.max_total <= 48'd268435456;
         cfg_ff.max_file  <= 48'd268435456;
         cfg_ff.max_path  <= 16'd255;
      end else if (cfg_wr) begin
         case (reg_sel)
            REG_MAGIC:     cfg_ff.magic     <= pwdata[31:0];
            REG_VERSION:   cfg_ff.version   <= pwdata[15:0];
            REG_MAX_FILES: cfg_ff.max_files <= pwdata[31:0];
            REG_MAX_TOTAL: cfg_ff.max_total <= pwdata[47:0];
            REG_MAX_FILE:  cfg_ff.max_file  <= pwdata[47:0];
            REG_MAX_PATH:  cfg_ff.max_path  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MAGIC:     prdata = {32'd0, cfg_ff.magic};
         REG_VERSION:   prdata = {48'd0, cfg_ff.version};
         REG_MAX_FILES: prdata = {32'd0, cfg_ff.max_files};
         REG_MAX_TOTAL: prdata = {16'd0, cfg_ff.max_total};
         REG_MAX_FILE:  prdata = {16'd0, cfg_ff.max_file};
         REG_MAX_PATH:  prdata = {48'd0, cfg_ff.max_path};
         default:       prdata = 64'd0;
      endcase
   end

   asp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_pop      (head_pop)
   );

   asp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_event_res  = rsp_data.event_res;
   assign rsp_out_byte   = rsp_data.out_byte;
   assign rsp_file_index = rsp_data.file_index;
   assign rsp_file_size  = rsp_data.file_size;
   assign rsp_error_code = rsp_data.error_code;
   assign rsp_last       = rsp_data.last;
endmodule

@@ hdl/asp_checker.sv @@
// Port-level checks for archive_stream_parser, attached by bind.
// Depends on asp_pkg.
module asp_port_checker import asp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_res,
   input logic [2:0] rsp_error_code,
   input logic       rsp_last
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res))
      else $error("result dropped while stalled");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_ERROR |-> rsp_error_code != ERR_NONE)
      else $error("error event without code");

   a_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_ERROR |-> rsp_error_code == ERR_NONE)
      else $error("code on non-error event");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_PATH || rsp_event_res == EV_ABSORB ||
                    rsp_event_res == EV_ACCEPT || rsp_event_res == EV_ERROR ||
                    rsp_event_res == EV_END) |-> rsp_last)
      else $error("single result not marked last");
endmodule

bind archive_stream_parser asp_port_checker u_asp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_res  (rsp_event_res),
   .rsp_error_code (rsp_error_code),
   .rsp_last       (rsp_last)
);
